// ===== rtl/core/minmax_linear_quantizer_assert.svh =====
// Assertion macros shared by the quantizer RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef MINMAX_LINEAR_QUANTIZER_ASSERT_SVH
`define MINMAX_LINEAR_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define MLQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MLQ_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLQ_ASSERT(label, clk, rst, prop, msg)
`define MLQ_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/mlq_pkg.sv =====
// Shared types and constants for the min/max linear quantizer.
// No dependencies.
`default_nettype none
package mlq_pkg;
  localparam int SetDepth = 64;
  localparam int QueueDepth = 4;
  localparam int SampleW = 16;
  localparam int ScaleW = 29;
  localparam int ZeroW = 32;
  localparam logic [4:0] BitCountReset = 5'd8;

  typedef enum logic [2:0] {
    ST_LOAD, ST_DIV_SCALE, ST_DIV_ZERO, ST_READ, ST_DIV_Q, ST_PUSH
  } back_state_t;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic               last;
  } front_word_t;
endpackage
`default_nettype wire

// ===== rtl/core/mlq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module mlq_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/mlq_divider.sv =====
// Restoring divider, one quotient bit per cycle: q = floor(num / den).
// Depends on nothing but its ports.
`default_nettype none
module mlq_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] num,
  input  wire logic [33:0] den,
  output logic             done,
  output logic [47:0]      quot
);
  logic [5:0]  count;
  logic        busy;
  logic [34:0] rem;
  logic [34:0] trial;

  assign trial = {rem[33:0], quot[47]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd47;
      end else if (busy) begin
        if (count == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
    end else if (busy) begin
      if (!trial[34]) begin
        rem  <= trial;
        quot <= {quot[46:0], 1'b1};
      end else begin
        rem  <= {rem[33:0], quot[47]};
        quot <= {quot[46:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mlq_front.sv =====
// Front end: accepts sample words and hands them to the back end via a queue.
// Depends on mlq_pkg.
`default_nettype none
module mlq_front #(
  parameter int QueueDepth = mlq_pkg::QueueDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [15:0]          s_tdata,
  input  wire logic                 s_tlast,
  output logic                      q_valid,
  input  wire logic                 q_pop,
  output mlq_pkg::front_word_t      q_word
);
  localparam int AW = $clog2(QueueDepth);
  mlq_pkg::front_word_t buf_q [QueueDepth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   used;
  logic          push;
  logic          pop;

  assign s_tready = (used != (AW+1)'(QueueDepth));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (used != '0);
  assign pop      = q_pop && q_valid;
  assign q_word   = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      used <= used + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr].value <= s_tdata;
      buf_q[wr_ptr].last  <= s_tlast;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mlq_back.sv =====
// Back end: stores samples, tracks min/max, then divides and emits codes.
// Depends on mlq_pkg, mlq_ram, mlq_divider and the assertion header.
`include "minmax_linear_quantizer_assert.svh"
`default_nettype none
module mlq_back #(
  parameter int SetDepth = mlq_pkg::SetDepth
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [4:0]          bit_count,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire mlq_pkg::front_word_t q_word,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [79:0]              m_tdata,
  output logic                     m_tlast
);
  localparam int AW = (SetDepth > 1) ? $clog2(SetDepth) : 1;
  localparam int CW = $clog2(SetDepth + 1);

  mlq_pkg::back_state_t state, state_next;
  logic signed [15:0] run_min, run_max;
  logic [CW-1:0] fill, idx;
  logic [16:0]   m_val;
  logic [16:0]   d_val;
  logic          deq;
  logic [28:0]   scale;
  logic signed [31:0] zero;
  logic [15:0]   rd_data;
  logic          div_start, div_done;
  logic [47:0]   div_num, div_quot;
  logic [33:0]   div_den;
  logic          neg;
  logic          store_en;
  logic          out_busy;
  logic [15:0]   q_code;
  logic signed [15:0] samp;
  logic [4:0]    b_eff;
  logic [32:0]   prod_mag;
  logic signed [15:0] min_upd, max_upd;
  logic [16:0]   s_mag;
  logic [16:0]   s_sum;
  logic          push_out;

  assign b_eff = (bit_count == 5'd0) ? 5'd1 : (bit_count > 5'd16) ? 5'd16 : bit_count;
  assign store_en = (state == mlq_pkg::ST_LOAD) && q_valid && (fill < CW'(SetDepth));
  assign samp = $signed(rd_data);
  assign s_mag = samp[15] ? (17'd0 - 17'(samp)) : 17'(samp);
  assign s_sum = s_mag + 17'd2048;

  // Running extremes including the word stored in this cycle.
  always_comb begin
    min_upd = run_min;
    max_upd = run_max;
    if (store_en && $signed(q_word.value) < run_min) min_upd = $signed(q_word.value);
    if (store_en && $signed(q_word.value) > run_max) max_upd = $signed(q_word.value);
  end

  mlq_ram #(.Width(16), .Depth(SetDepth)) u_ram (
    .clk(clk), .wr_en(store_en), .wr_addr(fill[AW-1:0]), .wr_data(q_word.value),
    .rd_addr(idx[AW-1:0]), .rd_data(rd_data)
  );

  mlq_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot)
  );

  // Divider operand selection; rounding half away uses floor((2n+d)/2d).
  always_comb begin
    div_num   = '0;
    div_den   = '0;
    prod_mag  = '0;
    neg       = 1'b0;
    case (state)
      mlq_pkg::ST_DIV_SCALE: begin
        div_num = 48'({d_val, 13'd0}) + 48'(m_val);
        div_den = 34'({m_val, 1'b1}) - 34'd1;
      end
      mlq_pkg::ST_DIV_ZERO: begin
        neg      = run_min > 0;
        prod_mag = 33'(neg ? 17'(run_min) : 17'(-run_min)) * 33'(m_val);
        div_num  = 48'({prod_mag, 1'b0}) + 48'(d_val);
        div_den  = 34'({d_val, 1'b0});
      end
      mlq_pkg::ST_DIV_Q: begin
        neg      = samp[15];
        prod_mag = 33'(s_mag) * 33'(m_val);
        div_num  = 48'({prod_mag, 1'b0}) + 48'(d_val);
        div_den  = 34'({d_val, 1'b0});
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      mlq_pkg::ST_LOAD:
        if (q_valid && q_word.last) begin
          state_next = (fill == '0 && !store_en) ? mlq_pkg::ST_LOAD : mlq_pkg::ST_DIV_SCALE;
        end
      mlq_pkg::ST_DIV_SCALE: if (div_done) state_next = mlq_pkg::ST_DIV_ZERO;
      mlq_pkg::ST_DIV_ZERO:  if (div_done || deq) state_next = mlq_pkg::ST_READ;
      mlq_pkg::ST_READ:      state_next = mlq_pkg::ST_DIV_Q;
      mlq_pkg::ST_DIV_Q:     if (div_done || deq) state_next = mlq_pkg::ST_PUSH;
      mlq_pkg::ST_PUSH:
        if (!out_busy) begin
          state_next = (idx == fill) ? mlq_pkg::ST_LOAD : mlq_pkg::ST_READ;
        end
      default: state_next = mlq_pkg::ST_LOAD;
    endcase
  end

  assign q_pop = (state == mlq_pkg::ST_LOAD) && q_valid;
  assign out_busy = m_tvalid && !m_tready;
  assign push_out = (state == mlq_pkg::ST_PUSH) && !out_busy;

  // Pulse divider start on the first cycle of each divide state; skipped in the zero and code states when deq.
  logic started;
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mlq_pkg::ST_LOAD;
      started <= 1'b0;
    end else begin
      state <= state_next;
      started <= (state_next == state) && (state == mlq_pkg::ST_DIV_SCALE ||
                 state == mlq_pkg::ST_DIV_ZERO || state == mlq_pkg::ST_DIV_Q);
    end
  end
  always_comb begin
    div_start = !started && !div_done &&
                (state == mlq_pkg::ST_DIV_SCALE ||
                 (state == mlq_pkg::ST_DIV_Q && !deq) ||
                 (state == mlq_pkg::ST_DIV_ZERO && !deq));
  end

  // With equal extremes the code is the sample rounded to whole units, a plain shift.
  logic signed [48:0] qfull;
  always_comb begin
    if (deq) begin
      qfull = neg ? -$signed(49'(s_sum[16:12])) : $signed(49'(s_sum[16:12]));
    end else begin
      qfull = neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
      qfull = qfull + 49'(zero);
    end
    if (qfull < 0) q_code = '0;
    else if (qfull > $signed(49'(m_val))) q_code = m_val[15:0];
    else q_code = qfull[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min  <= 16'sh7fff;
      run_max  <= -16'sh8000;
      fill     <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (push_out) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        mlq_pkg::ST_LOAD: begin
          if (store_en) fill <= fill + CW'(1);
          run_min <= min_upd;
          run_max <= max_upd;
          idx <= '0;
        end
        mlq_pkg::ST_DIV_Q: if (div_done || deq) idx <= idx + CW'(1);
        mlq_pkg::ST_PUSH:
          if (push_out && idx == fill) begin
            fill    <= '0;
            run_min <= 16'sh7fff;
            run_max <= -16'sh8000;
          end
        default: ;
      endcase
    end
  end

  logic [15:0] q_hold;
  logic signed [48:0] z_full;
  always_comb z_full = neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
  always_ff @(posedge clk) begin
    if (state == mlq_pkg::ST_LOAD) begin
      m_val <= 17'((18'd1 << b_eff) - 18'd1);
      d_val <= 17'(32'(max_upd) - 32'(min_upd));
      deq   <= (max_upd == min_upd);
    end
    if (state == mlq_pkg::ST_DIV_SCALE) begin
      deq <= (d_val == '0);
      if (d_val == '0) scale <= 29'h1000000;
      else if (div_done) scale <= div_quot[28:0];
    end
    if (state == mlq_pkg::ST_DIV_ZERO) begin
      if (deq) zero <= '0;
      else if (div_done) begin
        if (z_full > 49'sd2147483647) zero <= 32'sh7fffffff;
        else if (z_full < -49'sd2147483648) zero <= 32'sh80000000;
        else zero <= z_full[31:0];
      end
    end
    if (state == mlq_pkg::ST_DIV_Q && (div_done || deq)) q_hold <= q_code;
    if (push_out) begin
      m_tdata <= {3'b0, zero, scale, q_hold};
      m_tlast <= (idx == fill);
    end
  end

  `MLQ_ASSERT(a_fill_bound, clk, rst, fill <= CW'(SetDepth), "fill count past depth")
  `MLQ_ASSERT(a_pop_load, clk, rst, q_pop |-> state == mlq_pkg::ST_LOAD, "pop outside load")
  `MLQ_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
endmodule
`default_nettype wire

// ===== rtl/core/minmax_linear_quantizer.sv =====
// Min/max linear quantizer: collects up to SET_DEPTH samples, then emits
// one clipped code per sample. Samples are taken one per cycle through a
// four-word queue while the back end is loading; once it starts computing,
// the queue fills and s_tready drops until the last code of the set is
// pushed to the output. After the last sample the back end divides for the
// scale and then for the zero point; each code then costs a read, a divide
// and a push. When all samples of a set are equal, the zero-point and code
// divides are skipped. A push also waits while the previous word is not
// taken.
`default_nettype none
module minmax_linear_quantizer #(
  parameter int SET_DEPTH = mlq_pkg::SetDepth,
  parameter int QUEUE_DEPTH = mlq_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // sample
  input  wire logic        s_tlast,   // last_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // quant_value, scale_value, zero_point
  output logic             m_tlast    // last_out
);
  logic [4:0] bit_count;
  logic q_valid, q_pop;
  mlq_pkg::front_word_t q_word;

  always_ff @(posedge clk) begin
    if (rst) bit_count <= mlq_pkg::BitCountReset;
    else if (cfg_wr_en) bit_count <= cfg_wr_data;
  end

  mlq_front #(.QueueDepth(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tlast(s_tlast),
    .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
  );

  mlq_back #(.SetDepth(SET_DEPTH)) u_back (
    .clk(clk), .rst(rst), .bit_count(bit_count),
    .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb_minmax_linear_quantizer.sv =====
// Self-checking bench for the min/max linear quantizer: random and directed sample sets,
// a scoreboard predicting codes, scale and zero point. Depends on the RTL.
`default_nettype none
class quant_scoreboard;
  int signed store_q[$];
  int signed run_min, run_max;
  int bits;
  logic [15:0] exp_code[$];
  logic [28:0] exp_scale[$];
  logic [31:0] exp_zero[$];
  bit exp_last[$];
  int errors;
  int checked;

  function void clear_set();
    store_q.delete();
    run_min = 32767;
    run_max = -32768;
  endfunction

  function new();
    clear_set();
    bits = 8;
    errors = 0;
    checked = 0;
  endfunction

  // Rounds n/d half away from zero; d is positive.
  function longint round_div(longint n, longint d);
    longint mag, r;
    mag = (n < 0) ? -n : n;
    r = (2 * mag + d) / (2 * d);
    return (n < 0) ? -r : r;
  endfunction

  function void note_sample(logic [15:0] data, bit last);
    int b;
    longint m, d, z, sc, q;
    int signed x;
    x = $signed(data);
    if (store_q.size() < 64) begin
      store_q.push_back(x);
      if (x < run_min) run_min = x;
      if (x > run_max) run_max = x;
    end
    if (!last) return;
    b = (bits < 1) ? 1 : (bits > 16) ? 16 : bits;
    m = (longint'(1) << b) - 1;
    d = longint'(run_max) - longint'(run_min);
    if (d == 0) begin
      sc = longint'(1) << 24;
      z = 0;
    end else begin
      sc = (2 * d * 4096 + m) / (2 * m);
      z = round_div(-longint'(run_min) * m, d);
      if (z > 64'sd2147483647) z = 64'sd2147483647;
      if (z < -64'sd2147483648) z = -64'sd2147483648;
    end
    foreach (store_q[i]) begin
      if (d == 0) q = round_div(store_q[i], 4096);
      else q = round_div(longint'(store_q[i]) * m, d) + z;
      if (q < 0) q = 0;
      if (q > m) q = m;
      exp_code.push_back(q[15:0]);
      exp_scale.push_back(sc[28:0]);
      exp_zero.push_back(z[31:0]);
      exp_last.push_back(i == store_q.size() - 1);
    end
    clear_set();
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch on word %0d: %s got %0h expected %0h", checked, what, got, want);
    errors++;
  endtask

  task check_word(logic [79:0] data, bit last);
    if (exp_code.size() == 0) begin
      report("unexpected word", data[15:0], 0);
      return;
    end
    if (data[15:0] !== exp_code[0]) report("code", data[15:0], exp_code[0]);
    if (data[44:16] !== exp_scale[0]) report("scale", data[44:16], exp_scale[0]);
    if (data[76:45] !== exp_zero[0]) report("zero point", data[76:45], exp_zero[0]);
    if (data[79:77] !== 3'b0) report("pad", data[79:77], 0);
    if (last !== exp_last[0]) report("last", last, exp_last[0]);
    void'(exp_code.pop_front());
    void'(exp_scale.pop_front());
    void'(exp_zero.pop_front());
    void'(exp_last.pop_front());
    checked++;
  endtask

  function int pending();
    return exp_code.size();
  endfunction
endclass

module tb_minmax_linear_quantizer;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic cfg_wr_en;
  logic [4:0] cfg_wr_data;
  logic s_tvalid, s_tready, s_tlast;
  logic [15:0] s_tdata;
  logic m_tvalid, m_tready, m_tlast;
  logic [79:0] m_tdata;

  quant_scoreboard sb;
  int hold_cycles;
  bit calm;
  int sets_sent;

  minmax_linear_quantizer dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  // The valid stays high from one word to the next unless the sender idles.
  task send_word(logic [15:0] data, bit last);
    while (!calm && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(data, last);
    if (last) sets_sent++;
  endtask

  task wait_drain();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task set_bits(logic [4:0] b);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.bits = b;
    @(posedge clk);
  endtask

  // Sends a set of n samples; wide sets exercise the value range, narrow ones cluster.
  task send_set(int n, bit narrow);
    logic [15:0] base, v;
    base = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      v = narrow ? 16'(base + 16'($urandom_range(15))) : 16'($urandom);
      send_word(v, i == n - 1);
    end
  endtask

  initial begin
    logic [4:0] b;
    sb = new();
    rst = 1; cfg_wr_en = 0; cfg_wr_data = 0;
    s_tvalid = 0; s_tdata = 0; s_tlast = 0;
    hold_cycles = 0; calm = 0; sets_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, single sample, equal min and max, halves.
    send_word(16'h8000, 0); send_word(16'h7fff, 1);
    send_word(16'h1234, 1);
    send_word(16'h0800, 0); send_word(16'h0800, 0); send_word(16'hf800, 0);
    send_word(16'hf800, 0); send_word(16'h0800, 1);
    send_word(16'h1000, 0); send_word(16'h1000, 1);
    send_word(16'h0001, 0); send_word(16'h0003, 1);
    send_word(16'hffff, 0); send_word(16'hfffe, 1);
    set_bits(5'd1);
    send_word(16'h0000, 0); send_word(16'h0001, 0); send_word(16'h0002, 1);
    set_bits(5'd16);
    send_word(16'h7fff, 0); send_word(16'h7ffe, 0); send_word(16'h8000, 1);
    set_bits(5'd0);
    send_word(16'h4000, 0); send_word(16'hc000, 1);
    set_bits(5'd31);
    send_word(16'h0100, 0); send_word(16'h0200, 1);
    // Overfull store: samples past the depth are dropped.
    set_bits(5'd8);
    for (int i = 0; i < 70; i++) send_word(16'($urandom), i == 69);

    // Long receiver hold-off while the sender keeps offering.
    hold_cycles = 3000;
    send_set(40, 0);
    send_set(10, 0);
    wait_drain();

    for (int k = 0; k < 30; k++) begin
      if (k % 12 == 0) begin
        b = (k == 0) ? 5'd16 : (k == 12) ? 5'd1 : 5'($urandom_range(31));
        set_bits(b);
      end
      calm = (k >= 20 && k < 28);
      case ($urandom_range(9))
        0: send_set($urandom_range(64, 66), 0);
        1, 2: send_set($urandom_range(1, 8), 1);
        default: send_set($urandom_range(1, 12), 0);
      endcase
      if (k == 15) wait_drain();
    end
    calm = 0;
    wait_drain();

    $display("covered %0d sets and %0d output words across bit widths 0..31",
             sets_sent, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
